// File: hw/rtl/uart_frame_transmit_queue_assert.svh
`ifndef UART_FRAME_TRANSMIT_QUEUE_ASSERT_SVH
`define UART_FRAME_TRANSMIT_QUEUE_ASSERT_SVH

// ----------------------------------------------------------------------------
// Assertion macros for the frame transmit queue checker
// ----------------------------------------------------------------------------

// Same-cycle implication, off while reset is held.
`define UFTQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, live during reset as well.
`define UFTQ_ASSERT_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/uftq_pkg.sv
// ----------------------------------------------------------------------------
// uftq_pkg
// Shared types and codes for the frame ring transmit queue.
// ----------------------------------------------------------------------------
package uftq_pkg;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_START = 2'd1,
    KIND_DONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_TOO_LONG = 2'd2,
    ST_IGNORED  = 2'd3
  } status_t;

  // One stored frame byte; last marks the final byte of a frame.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } entry_t;

  // Per-request result fields apart from the transmitted byte.
  typedef struct packed {
    status_t status;
    logic    tx_valid;
    logic    busy;
  } result_t;

endpackage

// File: hw/rtl/uftq_if.sv
// ----------------------------------------------------------------------------
// uftq_in_if / uftq_out_if
// Valid/ready channels for requests and results of the transmit queue.
// ----------------------------------------------------------------------------
interface uftq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_data;
  logic       last_byte;

  modport source (output valid, kind, byte_data, last_byte, input ready);
  modport sink   (input valid, kind, byte_data, last_byte, output ready);
endinterface

interface uftq_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       busy_res;

  modport source (output valid, status, tx_valid, tx_byte, busy_res, input ready);
  modport sink   (input valid, status, tx_valid, tx_byte, busy_res, output ready);
endinterface

// File: hw/rtl/uftq_frame_mem.sv
// ----------------------------------------------------------------------------
// uftq_frame_mem
// Frame byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uftq_frame_mem import uftq_pkg::*; #(
  parameter int DEPTH = 512,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_entry,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_entry
);

  entry_t mem_r [DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_entry;
    end
  end

  // Hold the last byte read until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem_r[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

// File: hw/rtl/uftq_ctrl.sv
// ----------------------------------------------------------------------------
// uftq_ctrl
// Ring pointers, fill and send counters, busy flag; decides each request.
// ----------------------------------------------------------------------------
module uftq_ctrl import uftq_pkg::*; #(
  parameter int QUEUE_SLOTS     = 8,
  parameter int FRAME_MAX_BYTES = 64,
  localparam int SLOT_W = $clog2(QUEUE_SLOTS),
  localparam int CNT_W  = $clog2(FRAME_MAX_BYTES + 1),
  localparam int ADDR_W = $clog2(QUEUE_SLOTS * FRAME_MAX_BYTES)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  kind_t             kind,
  input  logic [7:0]        byte_data,
  input  logic              last_byte,
  input  logic              last_sent,
  output result_t           res,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output entry_t            wr_entry,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
  localparam logic [CNT_W-1:0]  FMAX_C    = CNT_W'(FRAME_MAX_BYTES);
  localparam logic [ADDR_W-1:0] FMAX_A    = ADDR_W'(FRAME_MAX_BYTES);

  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              busy_r, busy_nxt;
  logic              drop_r, drop_nxt;
  logic [SLOT_W-1:0] rd_slot;
  logic [CNT_W-1:0]  rd_pos;
  logic              wr_req;
  logic              rd_req;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_inc;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : SLOT_W'(s + 1'b1);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [CNT_W-1:0]  p);
    return ADDR_W'(ADDR_W'(s) * FMAX_A) + ADDR_W'(p);
  endfunction

  assign head_inc = slot_inc(head_r);
  assign tail_inc = slot_inc(tail_r);

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    pos_nxt      = pos_r;
    fill_nxt     = fill_r;
    busy_nxt     = busy_r;
    drop_nxt     = drop_r;
    wr_req       = 1'b0;
    rd_req       = 1'b0;
    rd_slot      = head_r;
    rd_pos       = pos_r;
    res.status   = ST_IGNORED;
    res.tx_valid = 1'b0;
    case (kind)
      KIND_PUSH: begin
        if (drop_r || fill_r == FMAX_C) begin
          // overlong frame: discard bytes until its last one
          drop_nxt   = 1'b1;
          res.status = ST_TOO_LONG;
          if (last_byte) begin
            drop_nxt = 1'b0;
            fill_nxt = '0;
          end
        end else begin
          wr_req     = 1'b1;
          fill_nxt   = CNT_W'(fill_r + 1'b1);
          res.status = ST_OK;
          if (last_byte) begin
            if (tail_inc == head_r) begin
              res.status = ST_FULL;
            end else begin
              tail_nxt = tail_inc;
            end
            fill_nxt = '0;
          end
        end
      end
      KIND_START: begin
        if (head_r != tail_r && !busy_r) begin
          rd_req       = 1'b1;
          pos_nxt      = CNT_W'(pos_r + 1'b1);
          busy_nxt     = 1'b1;
          res.tx_valid = 1'b1;
          res.status   = ST_OK;
        end
      end
      KIND_DONE: begin
        if (busy_r) begin
          res.status = ST_OK;
          if (!last_sent) begin
            rd_req       = 1'b1;
            pos_nxt      = CNT_W'(pos_r + 1'b1);
            res.tx_valid = 1'b1;
          end else begin
            // retire head frame, start the next one if any
            head_nxt = head_inc;
            pos_nxt  = '0;
            if (head_inc != tail_r) begin
              rd_req       = 1'b1;
              rd_slot      = head_inc;
              rd_pos       = '0;
              pos_nxt      = CNT_W'(1);
              res.tx_valid = 1'b1;
            end else begin
              busy_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.busy = busy_nxt;
  end

  assign wr_en    = en && wr_req;
  assign wr_addr  = slot_addr(tail_r, fill_r);
  assign wr_entry = '{last: last_byte, data: byte_data};
  assign rd_en    = en && rd_req;
  assign rd_addr  = slot_addr(rd_slot, rd_pos);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      pos_r  <= '0;
      fill_r <= '0;
      busy_r <= 1'b0;
      drop_r <= 1'b0;
    end else if (en) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      pos_r  <= pos_nxt;
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      drop_r <= drop_nxt;
    end
  end

endmodule

// File: hw/rtl/uart_frame_transmit_queue.sv
// ----------------------------------------------------------------------------
// uart_frame_transmit_queue
// Ring of frame slots feeding a byte transmitter, one request in, one result out.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  in_ch   | in  | kind[1:0], byte_data[7:0], last_byte
//  out_ch  | out | status[1:0], tx_valid, tx_byte[7:0], busy_res
//
//  One request accepted per cycle unless the result side stalls; each request goes
//  through the input register, then the result register with the frame store read port.
//  No reset sweep: the byte store is read only where a committed frame lives.
//  Reset (rst_n low, synchronous) empties the ring and clears busy.
//  A stalled result holds; one more request then waits in the input register.
// ----------------------------------------------------------------------------
module uart_frame_transmit_queue import uftq_pkg::*; #(
  parameter int QUEUE_SLOTS     = 8,
  parameter int FRAME_MAX_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  uftq_in_if.sink    in_ch,
  uftq_out_if.source out_ch
);

  localparam int MEM_DEPTH = QUEUE_SLOTS * FRAME_MAX_BYTES;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic              s1_valid_r;
  kind_t             s1_kind_r;
  logic [7:0]        s1_byte_r;
  logic              s1_last_r;
  logic              s2_valid_r;
  result_t           s2_res_r;
  logic              adv;
  logic              in_acc;
  result_t           res;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_entry;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_entry;

  assign adv          = s1_valid_r && (!s2_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= kind_t'(in_ch.kind);
      s1_byte_r <= in_ch.byte_data;
      s1_last_r <= in_ch.last_byte;
    end
  end

  uftq_ctrl #(
    .QUEUE_SLOTS     (QUEUE_SLOTS),
    .FRAME_MAX_BYTES (FRAME_MAX_BYTES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .kind      (s1_kind_r),
    .byte_data (s1_byte_r),
    .last_byte (s1_last_r),
    .last_sent (rd_entry.last),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  uftq_frame_mem #(
    .DEPTH (MEM_DEPTH)
  ) u_frame_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_res_r <= res;
    end
  end

  assign out_ch.valid    = s2_valid_r;
  assign out_ch.status   = s2_res_r.status;
  assign out_ch.tx_valid = s2_res_r.tx_valid;
  assign out_ch.tx_byte  = s2_res_r.tx_valid ? rd_entry.data : 8'h00;
  assign out_ch.busy_res = s2_res_r.busy;

endmodule

// File: hw/rtl/uftq_checker.sv
// ----------------------------------------------------------------------------
// uftq_checker
// Port-level checks on the transmit queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "uart_frame_transmit_queue_assert.svh"

module uftq_checker import uftq_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic       out_tx_valid,
  input logic [7:0] out_tx_byte,
  input logic       out_busy_res
);

  `UFTQ_ASSERT_IMP(a_tx_ok_busy, clk, rst_n, out_valid && out_tx_valid, out_status == ST_OK && out_busy_res, "byte sent without ok status or busy")
  `UFTQ_ASSERT_IMP(a_tx_byte_zero, clk, rst_n, out_valid && !out_tx_valid, out_tx_byte == 8'h00, "tx_byte nonzero with no byte sent")
  `UFTQ_ASSERT_IMP(a_ready_when_drained, clk, rst_n, !out_valid, in_ready, "request refused with result side empty")
  `UFTQ_ASSERT_NEXT(a_reset_clears_out, clk, !rst_n, !out_valid, "result shown right after reset")

endmodule

bind uart_frame_transmit_queue uftq_checker u_uftq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_status   (out_ch.status),
  .out_tx_valid (out_ch.tx_valid),
  .out_tx_byte  (out_ch.tx_byte),
  .out_busy_res (out_ch.busy_res)
);
